// ===== design/record_group_index_unit_macros.svh =====
// Assertion macros for the record group index unit.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef RECORD_GROUP_INDEX_UNIT_MACROS_SVH
`define RECORD_GROUP_INDEX_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Check that a property holds at every clock edge outside reset.
`define RGI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("record_group_index_unit: check failed");
// Check that a condition never holds outside reset.
`define RGI_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("record_group_index_unit: forbidden condition seen");
`else
`define RGI_ASSERT(label, clk, rst, prop)
`define RGI_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== design/rgi_pkg.sv =====
// Shared types and codes for the record group index unit.
// No dependencies; imported by record_group_index_unit, the checker and the testbench.
package rgi_pkg;

   localparam int FUNC_W   = 2;
   localparam int VALUE_W  = 8;
   localparam int RECORD_W = 10;
   localparam int GSIZE_W  = 11;
   localparam int LIVE_W   = 11;
   localparam int GTOTAL_W = 9;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_REC,
      S_GRP
   } state_type;

endpackage

// ===== design/rgi_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Standalone; holds the record table and the group count table.
module rgi_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/record_group_index_unit.sv =====
// Record group index unit: files records under dense value ids. An insert takes the
// next record id (ids are never reused), an erase frees a record and shrinks its
// group, a lookup returns a record's value; every result carries live record and
// non-empty group counts. After reset the unit sweeps the group count table, one
// entry per cycle, and takes no request until done. Then an insert reads only the
// group count table, and an erase or lookup reads the record table first and, for a
// live record, the group count table next, in a chain of registered reads. A pending
// result in the output register does not block the next request from being
// accepted, but holds it in its last step until the result leaves.
// Depends on rgi_pkg, rgi_ram and record_group_index_unit_macros.svh.
`include "record_group_index_unit_macros.svh"

module record_group_index_unit #(
   parameter int MAX_RECORDS = 1024,
   parameter int MAX_VALUES  = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rgi_pkg::FUNC_W-1:0]     req_func,
   input  logic [rgi_pkg::VALUE_W-1:0]    req_value_id,
   input  logic [rgi_pkg::RECORD_W-1:0]   req_record_id,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rgi_pkg::RECORD_W-1:0]   rsp_out_record,
   output logic [rgi_pkg::VALUE_W-1:0]    rsp_out_value,
   output logic [rgi_pkg::GSIZE_W-1:0]    rsp_group_size,
   output logic [rgi_pkg::LIVE_W-1:0]     rsp_live_records,
   output logic [rgi_pkg::GTOTAL_W-1:0]   rsp_group_total,
   output logic [rgi_pkg::STATUS_W-1:0]   rsp_status
);

   import rgi_pkg::*;

   localparam int RAW  = $clog2(MAX_RECORDS);
   localparam int VAW  = $clog2(MAX_VALUES);
   localparam int CW   = $clog2(MAX_RECORDS + 1);
   localparam int GW   = $clog2(MAX_VALUES + 1);
   localparam int RECW = VALUE_W + 1;

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [VALUE_W-1:0]  v_ff, v_in;
   logic [RECORD_W-1:0] rec_ff, rec_in;
   logic                refuse_ff, refuse_in;
   logic                inrange_ff, inrange_in;
   logic [CW-1:0]       next_id_ff, next_id_in;
   logic [CW-1:0]       live_ff, live_in;
   logic [GW-1:0]       groups_ff, groups_in;
   logic [VAW-1:0]      clr_idx_ff, clr_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RECORD_W-1:0] rsp_record_ff, rsp_record_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [GSIZE_W-1:0]  rsp_gsize_ff, rsp_gsize_in;
   logic [LIVE_W-1:0]   rsp_live_ff, rsp_live_in;
   logic [GTOTAL_W-1:0] rsp_gtotal_ff, rsp_gtotal_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic            rec_we, rec_re;
   logic [RAW-1:0]  rec_wa, rec_ra;
   logic [RECW-1:0] rec_wd, rec_rd;
   logic            grp_we, grp_re;
   logic [VAW-1:0]  grp_wa, grp_ra;
   logic [CW-1:0]   grp_wd, grp_rd;

   logic          accept, can_emit, live_hit, is_full;
   logic [CW-1:0] cnt_dec;

   rgi_ram #(.DEPTH(MAX_RECORDS), .WIDTH(RECW)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_wa),
      .wr_data (rec_wd),
      .rd_en   (rec_re),
      .rd_addr (rec_ra),
      .rd_data (rec_rd)
   );

   rgi_ram #(.DEPTH(MAX_VALUES), .WIDTH(CW)) u_grp_ram (
      .clock   (clock),
      .wr_en   (grp_we),
      .wr_addr (grp_wa),
      .wr_data (grp_wd),
      .rd_en   (grp_re),
      .rd_addr (grp_ra),
      .rd_data (grp_rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign can_emit  = !rsp_valid_ff || !rsp_stall;
   assign is_full   = (32'(next_id_ff) >= MAX_RECORDS);
   // ids at or past next_id were never handed out, so their entries count as free
   assign live_hit  = inrange_ff && (32'(rec_ff) < 32'(next_id_ff)) && rec_rd[RECW-1];
   assign cnt_dec   = (grp_rd != '0) ? (grp_rd - CW'(1)) : grp_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         next_id_ff   <= '0;
         live_ff      <= '0;
         groups_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         next_id_ff   <= next_id_in;
         live_ff      <= live_in;
         groups_ff    <= groups_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      v_ff          <= v_in;
      rec_ff        <= rec_in;
      refuse_ff     <= refuse_in;
      inrange_ff    <= inrange_in;
      rsp_record_ff <= rsp_record_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_gsize_ff  <= rsp_gsize_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_gtotal_ff <= rsp_gtotal_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      next_id_in    = next_id_ff;
      live_in       = live_ff;
      groups_in     = groups_ff;
      func_in       = func_ff;
      v_in          = v_ff;
      rec_in        = rec_ff;
      refuse_in     = refuse_ff;
      inrange_in    = inrange_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_record_in = rsp_record_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_gsize_in  = rsp_gsize_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_gtotal_in = rsp_gtotal_ff;
      rsp_status_in = rsp_status_ff;
      rec_we        = 1'b0;
      rec_wa        = RAW'(next_id_ff);
      rec_wd        = {1'b1, v_ff};
      rec_re        = 1'b0;
      rec_ra        = RAW'(req_record_id);
      grp_we        = 1'b0;
      grp_wa        = VAW'(v_ff);
      grp_wd        = '0;
      grp_re        = 1'b0;
      grp_ra        = VAW'(req_value_id);

      unique case (state_ff)
         S_CLEAR: begin
            grp_we     = 1'b1;
            grp_wa     = clr_idx_ff;
            clr_idx_in = clr_idx_ff + VAW'(1);
            if (clr_idx_ff == VAW'(MAX_VALUES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               func_in    = req_func;
               v_in       = req_value_id;
               rec_in     = req_record_id;
               refuse_in  = (32'(req_value_id) >= MAX_VALUES);
               inrange_in = (32'(req_record_id) < MAX_RECORDS);
               if (req_func == FUNC_INSERT) begin
                  grp_re   = 1'b1;
                  state_in = S_GRP;
               end else begin
                  rec_re   = 1'b1;
                  state_in = S_REC;
               end
            end
         end
         S_REC: begin
            if (live_hit) begin
               v_in     = rec_rd[VALUE_W-1:0];
               grp_re   = 1'b1;
               grp_ra   = VAW'(rec_rd[VALUE_W-1:0]);
               state_in = S_GRP;
            end else if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_record_in = rec_ff;
               rsp_value_in  = '0;
               rsp_gsize_in  = '0;
               rsp_live_in   = LIVE_W'(live_ff);
               rsp_gtotal_in = GTOTAL_W'(groups_ff);
               rsp_status_in = STATUS_UNKNOWN;
               state_in      = S_IDLE;
            end
         end
         S_GRP: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = v_ff;
               rsp_record_in = rec_ff;
               rsp_gsize_in  = GSIZE_W'(grp_rd);
               rsp_status_in = STATUS_OK;
               live_in       = live_ff;
               groups_in     = groups_ff;
               state_in      = S_IDLE;
               unique case (func_ff)
                  FUNC_INSERT: begin
                     rsp_record_in = '0;
                     rsp_status_in = STATUS_FULL;
                     if (refuse_ff) begin
                        rsp_gsize_in = '0;
                     end else if (!is_full) begin
                        rsp_record_in = RECORD_W'(next_id_ff);
                        rsp_status_in = STATUS_OK;
                        rsp_gsize_in  = GSIZE_W'(grp_rd + CW'(1));
                        rec_we        = 1'b1;
                        grp_we        = 1'b1;
                        grp_wd        = grp_rd + CW'(1);
                        next_id_in    = next_id_ff + CW'(1);
                        live_in       = live_ff + CW'(1);
                        if (grp_rd == '0) begin
                           groups_in = groups_ff + GW'(1);
                        end
                     end
                  end
                  FUNC_ERASE: begin
                     rec_we       = 1'b1;
                     rec_wa       = RAW'(rec_ff);
                     rec_wd       = {1'b0, v_ff};
                     grp_we       = 1'b1;
                     grp_wd       = cnt_dec;
                     rsp_gsize_in = GSIZE_W'(cnt_dec);
                     if (live_ff != '0) begin
                        live_in = live_ff - CW'(1);
                     end
                     // drop the group when its last member leaves
                     if (grp_rd != '0 && cnt_dec == '0 && groups_ff != '0) begin
                        groups_in = groups_ff - GW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_live_in   = LIVE_W'(live_in);
               rsp_gtotal_in = GTOTAL_W'(groups_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_record   = rsp_record_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_group_size   = rsp_gsize_ff;
   assign rsp_live_records = rsp_live_ff;
   assign rsp_group_total  = rsp_gtotal_ff;
   assign rsp_status       = rsp_status_ff;

   `RGI_ASSERT(a_live_le_ids, clock, reset, live_ff <= next_id_ff)
   `RGI_ASSERT(a_groups_le_live, clock, reset, 32'(groups_ff) <= 32'(live_ff))
   `RGI_ASSERT(a_rsp_from_work, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_REC || $past(state_ff) == S_GRP))
   `RGI_NEVER(a_no_ids_while_clearing, clock, reset, state_ff == S_CLEAR && next_id_ff != '0)

endmodule

// ===== sim/record_group_index_checker.sv =====
// Checker for the record group index unit: predicts every response beat from the
// request beats it sees and compares the two field by field.
// Depends on rgi_pkg for field widths and operation and status codes.
`timescale 1ns / 100ps

module record_group_index_checker #(
   parameter int MAX_RECORDS = 1024,
   parameter int MAX_VALUES  = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [rgi_pkg::FUNC_W-1:0]     req_func,
   input  logic [rgi_pkg::VALUE_W-1:0]    req_value_id,
   input  logic [rgi_pkg::RECORD_W-1:0]   req_record_id,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [rgi_pkg::RECORD_W-1:0]   rsp_out_record,
   input  logic [rgi_pkg::VALUE_W-1:0]    rsp_out_value,
   input  logic [rgi_pkg::GSIZE_W-1:0]    rsp_group_size,
   input  logic [rgi_pkg::LIVE_W-1:0]     rsp_live_records,
   input  logic [rgi_pkg::GTOTAL_W-1:0]   rsp_group_total,
   input  logic [rgi_pkg::STATUS_W-1:0]   rsp_status,
   output int                             mismatches,
   output int                             outstanding
);

   import rgi_pkg::*;

   typedef struct {
      logic [RECORD_W-1:0] record;
      logic [VALUE_W-1:0]  value;
      logic [GSIZE_W-1:0]  group_size;
      logic [LIVE_W-1:0]   live;
      logic [GTOTAL_W-1:0] groups;
      logic [STATUS_W-1:0] status;
   } index_reply_type;

   index_reply_type     pending_replies[$];
   bit                  record_held[MAX_RECORDS];
   logic [VALUE_W-1:0]  record_value[MAX_RECORDS];
   int unsigned         group_members[MAX_VALUES];
   int unsigned         next_record;
   int unsigned         held_total;
   int unsigned         busy_groups;

   // Apply one request to the shadow index and return the reply it should give.
   function automatic index_reply_type index_update(logic [FUNC_W-1:0] func,
                                                    logic [VALUE_W-1:0] vid,
                                                    logic [RECORD_W-1:0] rid);
      index_reply_type reply;
      int unsigned     v;
      reply.record     = '0;
      reply.value      = '0;
      reply.group_size = '0;
      reply.status     = STATUS_OK;
      if (func == FUNC_INSERT) begin
         reply.value = vid;
         if (vid >= MAX_VALUES) begin
            reply.status = STATUS_FULL;
         end else if (next_record >= MAX_RECORDS) begin
            reply.status     = STATUS_FULL;
            reply.group_size = GSIZE_W'(group_members[vid]);
         end else begin
            reply.record = RECORD_W'(next_record);
            record_held[next_record]  = 1'b1;
            record_value[next_record] = vid;
            next_record++;
            if (group_members[vid] == 0) busy_groups++;
            group_members[vid]++;
            held_total++;
            reply.group_size = GSIZE_W'(group_members[vid]);
         end
      end else if (rid >= MAX_RECORDS || !record_held[rid]) begin
         reply.record = rid;
         reply.status = STATUS_UNKNOWN;
      end else begin
         v = 32'(record_value[rid]);
         reply.record = rid;
         reply.value  = VALUE_W'(v);
         // anything but erase, the spare code included, is a plain lookup
         if (func == FUNC_ERASE) begin
            record_held[rid] = 1'b0;
            if (group_members[v] > 0) begin
               group_members[v]--;
               if (group_members[v] == 0 && busy_groups > 0) busy_groups--;
            end
            if (held_total > 0) held_total--;
         end
         reply.group_size = GSIZE_W'(group_members[v]);
      end
      reply.live   = LIVE_W'(held_total);
      reply.groups = GTOTAL_W'(busy_groups);
      return reply;
   endfunction

   function automatic int field_differs(string name, int unsigned want, int unsigned got);
      if (want == got) return 0;
      $error("%s expected %0d actual %0d", name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin : watch
      index_reply_type want;
      int              bad;
      if (reset) begin
         pending_replies.delete();
         foreach (record_held[i]) record_held[i] = 1'b0;
         foreach (group_members[i]) group_members[i] = 0;
         next_record = 0;
         held_total  = 0;
         busy_groups = 0;
         mismatches  = 0;
      end else begin
         // pop before adding: a beat can never answer a request of the same edge
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               $error("response beat with no request waiting");
               mismatches++;
            end else begin
               want = pending_replies.pop_front();
               bad  = field_differs("out_record", 32'(want.record), 32'(rsp_out_record));
               bad += field_differs("out_value", 32'(want.value), 32'(rsp_out_value));
               bad += field_differs("group_size", 32'(want.group_size),
                                    32'(rsp_group_size));
               bad += field_differs("live_records", 32'(want.live), 32'(rsp_live_records));
               bad += field_differs("group_total", 32'(want.groups), 32'(rsp_group_total));
               bad += field_differs("status", 32'(want.status), 32'(rsp_status));
               mismatches += bad;
            end
         end
         if (req_valid && !req_stall) begin
            want = index_update(req_func, req_value_id, req_record_id);
            pending_replies.insert(pending_replies.size(), want);
         end
      end
      outstanding = pending_replies.size();
   end

endmodule

// ===== sim/tb.sv =====
// Top of the record group index testbench: clock, reset, request stimulus with
// random gaps, random response stalls, and the verdict.
// Depends on rgi_pkg, record_group_index_unit and record_group_index_checker.
`timescale 1ns / 100ps

module tb;
   import rgi_pkg::*;

   localparam int MAX_RECORDS = 1024;
   localparam int MAX_VALUES  = 256;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [FUNC_W-1:0]     req_func = FUNC_INSERT;
   logic [VALUE_W-1:0]    req_value_id = '0;
   logic [RECORD_W-1:0]   req_record_id = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [RECORD_W-1:0]   rsp_out_record;
   logic [VALUE_W-1:0]    rsp_out_value;
   logic [GSIZE_W-1:0]    rsp_group_size;
   logic [LIVE_W-1:0]     rsp_live_records;
   logic [GTOTAL_W-1:0]   rsp_group_total;
   logic [STATUS_W-1:0]   rsp_status;

   int          mismatches;
   int          outstanding;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned issued = 0;
   int unsigned cycles = 0;

   always #10 clock = ~clock;

   record_group_index_unit #(
      .MAX_RECORDS (MAX_RECORDS),
      .MAX_VALUES  (MAX_VALUES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_value_id     (req_value_id),
      .req_record_id    (req_record_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_record   (rsp_out_record),
      .rsp_out_value    (rsp_out_value),
      .rsp_group_size   (rsp_group_size),
      .rsp_live_records (rsp_live_records),
      .rsp_group_total  (rsp_group_total),
      .rsp_status       (rsp_status)
   );

   record_group_index_checker #(
      .MAX_RECORDS (MAX_RECORDS),
      .MAX_VALUES  (MAX_VALUES)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_value_id     (req_value_id),
      .req_record_id    (req_record_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_record   (rsp_out_record),
      .rsp_out_value    (rsp_out_value),
      .rsp_group_size   (rsp_group_size),
      .rsp_live_records (rsp_live_records),
      .rsp_group_total  (rsp_group_total),
      .rsp_status       (rsp_status),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // Offer one request beat and hold it until accepted.
   task automatic send_beat(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] vid,
                            logic [RECORD_W-1:0] rid);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_value_id  <= vid;
      req_record_id <= rid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (func == FUNC_INSERT && issued < MAX_RECORDS) issued++;
   endtask

   // Random request: erase and lookup mostly aim at ids already handed out;
   // piling sends most inserts to the top value id to grow one large group.
   task automatic send_random_beat(int unsigned insert_pct, bit pile);
      logic [FUNC_W-1:0]   func;
      logic [VALUE_W-1:0]  vid;
      logic [RECORD_W-1:0] rid;
      int unsigned         sel;
      vid = $urandom_range(1) ? VALUE_W'($urandom_range(255)) : VALUE_W'($urandom_range(7));
      rid = RECORD_W'($urandom_range(1023));
      if (pile && $urandom_range(9) < 7) vid = 8'hFF;
      if ($urandom_range(99) < insert_pct) begin
         func = FUNC_INSERT;
      end else begin
         sel = $urandom_range(9);
         if (sel < 5) func = FUNC_ERASE;
         else if (sel < 9) func = FUNC_LOOKUP;
         else func = FUNC_SPARE;
         if (issued != 0 && $urandom_range(9) != 0) rid = RECORD_W'($urandom_range(issued - 1));
      end
      send_beat(func, vid, rid);
   endtask

   task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned beats,
                            int unsigned insert_pct, bit pile);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (beats) send_random_beat(insert_pct, pile);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty index: every record is unknown
      send_beat(FUNC_LOOKUP, 8'h00, 10'd0);
      send_beat(FUNC_ERASE, 8'hFF, 10'd1023);
      send_beat(FUNC_SPARE, 8'hFF, 10'd1023);
      // first members of two groups, then a second member
      send_beat(FUNC_INSERT, 8'h00, 10'd1023);
      send_beat(FUNC_INSERT, 8'hFF, 10'd0);
      send_beat(FUNC_INSERT, 8'h00, 10'd512);
      send_beat(FUNC_LOOKUP, 8'hFF, 10'd0);
      send_beat(FUNC_SPARE, 8'h00, 10'd1);
      // empty the top group, then touch the freed record again
      send_beat(FUNC_ERASE, 8'h55, 10'd1);
      send_beat(FUNC_ERASE, 8'hAA, 10'd1);
      send_beat(FUNC_LOOKUP, 8'h00, 10'd1);
      send_beat(FUNC_SPARE, 8'h00, 10'd1);
      // drain to an empty index
      send_beat(FUNC_ERASE, 8'h00, 10'd0);
      send_beat(FUNC_LOOKUP, 8'h00, 10'd2);
      send_beat(FUNC_ERASE, 8'hFF, 10'd2);
      send_beat(FUNC_LOOKUP, 8'h00, 10'd2);
      // refill: ids keep counting up
      send_beat(FUNC_INSERT, 8'h80, 10'd0);
      send_beat(FUNC_INSERT, 8'h7F, 10'd1023);
      send_beat(FUNC_LOOKUP, 8'h00, 10'd3);
      send_beat(FUNC_LOOKUP, 8'hFF, 10'd4);
      send_beat(FUNC_LOOKUP, 8'h00, 10'd1023);

      run_phase(0, 0, 170, 45, 1'b0);
      run_phase(66, 0, 170, 45, 1'b0);
      run_phase(0, 66, 170, 45, 1'b0);
      // grow one large group under mixed gaps and stalls
      run_phase(20, 20, 170, 70, 1'b1);

      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== record_group_index_unit.f =====
+incdir+design
design/rgi_pkg.sv
design/rgi_ram.sv
design/record_group_index_unit.sv
sim/record_group_index_checker.sv
sim/tb.sv
